/* src/abbx_pkg.sv */
// ----------------------------------------------------------------------------
// abbx_pkg
// Shared types, constants and helpers for the affine bounding box transform.
// ----------------------------------------------------------------------------
package abbx_pkg;

   localparam int unsigned WORD_W    = 32;
   localparam int unsigned FRAC_W    = 16;
   localparam int unsigned PROD_W    = WORD_W + FRAC_W;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned BOX_W     = 4 * WORD_W;
   localparam int unsigned NUM_PROD  = 8;
   localparam int unsigned NUM_CORN  = 4;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_A  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_B  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_C  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_D  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SHIFT_X = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SHIFT_Y = 3'd5;

   // Product slots: coefficient times coordinate, lo or hi bound.
   localparam int unsigned P_AX_LO = 0;
   localparam int unsigned P_AX_HI = 1;
   localparam int unsigned P_CY_LO = 2;
   localparam int unsigned P_CY_HI = 3;
   localparam int unsigned P_BX_LO = 4;
   localparam int unsigned P_BX_HI = 5;
   localparam int unsigned P_DY_LO = 6;
   localparam int unsigned P_DY_HI = 7;

   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic [PROD_W-1:0]        prod_type;

   localparam word_type ONE_Q16    = 32'sd65536;
   localparam prod_type ROUND_BIAS = 48'h8000;

   typedef struct packed {
      word_type x_lo;
      word_type y_lo;
      word_type x_hi;
      word_type y_hi;
   } box_type;

   typedef struct packed {
      logic st1;
      logic st2;
      logic st3;
      logic st4;
   } stage_en_type;

   // Round to nearest and drop the fraction; only the low product bits matter.
   function automatic word_type fx_round(input prod_type p);
      prod_type t;
      t = p + ROUND_BIAS;
      return word_type'(t[PROD_W-1:FRAC_W]);
   endfunction

   function automatic word_type smin(input word_type a, input word_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic word_type smax(input word_type a, input word_type b);
      return (a > b) ? a : b;
   endfunction

endpackage

/* src/affine_bbox_transform_q16_unit.sv */
// ----------------------------------------------------------------------------
// affine_bbox_transform_q16_unit
// Pipeline: an accepted req beat reaches its rsp beat through the multiply,
// corner sum, pairwise min/max, and final min/max with output register stages.
// Throughput: one beat per cycle; each stage holds only when the stage after
// it is full and stalled, so bubbles close up. Synchronous reset empties the
// pipeline and loads the identity matrix with no translation.
// ----------------------------------------------------------------------------
module affine_bbox_transform_q16_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [abbx_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [abbx_pkg::WORD_W-1:0]       csr_wdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // in_x_lo [31:0], in_y_lo [63:32], in_x_hi [95:64], in_y_hi [127:96]
   input  logic [abbx_pkg::BOX_W-1:0]        req_tdata,
   // in_empty [0]
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // out_x_lo [31:0], out_y_lo [63:32], out_x_hi [95:64], out_y_hi [127:96]
   output logic [abbx_pkg::BOX_W-1:0]        rsp_tdata,
   // out_empty [0]
   output logic                              rsp_tuser
);
   import abbx_pkg::*;

   word_type coef_a_ff, coef_b_ff, coef_c_ff, coef_d_ff, shift_x_ff, shift_y_ff;

   logic         v1_ff, v2_ff, v3_ff, v4_ff;
   logic         rdy1, rdy2, rdy3, rdy4;
   stage_en_type stage_en;

   box_type  req_box;
   box_type  box1_ff, box2_ff;
   logic     empty1_ff, empty2_ff;
   word_type op_a [NUM_PROD];
   word_type op_b [NUM_PROD];
   prod_type prod [NUM_PROD];
   word_type cx [NUM_CORN];
   word_type cy [NUM_CORN];
   box_type  res_box;
   logic     res_empty;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_a_ff  <= ONE_Q16;
         coef_b_ff  <= '0;
         coef_c_ff  <= '0;
         coef_d_ff  <= ONE_Q16;
         shift_x_ff <= '0;
         shift_y_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_COEF_A:  coef_a_ff  <= csr_wdata;
            CSR_COEF_B:  coef_b_ff  <= csr_wdata;
            CSR_COEF_C:  coef_c_ff  <= csr_wdata;
            CSR_COEF_D:  coef_d_ff  <= csr_wdata;
            CSR_SHIFT_X: shift_x_ff <= csr_wdata;
            CSR_SHIFT_Y: shift_y_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // A stage loads whenever it is empty or its contents move on.
   assign rdy4       = !v4_ff || rsp_tready;
   assign rdy3       = !v3_ff || rdy4;
   assign rdy2       = !v2_ff || rdy3;
   assign rdy1       = !v1_ff || rdy2;
   assign req_tready = rdy1;

   assign stage_en.st1 = rdy1;
   assign stage_en.st2 = rdy2;
   assign stage_en.st3 = rdy3;
   assign stage_en.st4 = rdy4;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_tvalid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   assign req_box.x_lo = req_tdata[WORD_W-1:0];
   assign req_box.y_lo = req_tdata[2*WORD_W-1:WORD_W];
   assign req_box.x_hi = req_tdata[3*WORD_W-1:2*WORD_W];
   assign req_box.y_hi = req_tdata[4*WORD_W-1:3*WORD_W];

   // The raw bounds travel alongside for the null rectangle bypass.
   always_ff @(posedge clock) begin
      if (stage_en.st1) begin
         box1_ff   <= req_box;
         empty1_ff <= req_tuser;
      end
      if (stage_en.st2) begin
         box2_ff   <= box1_ff;
         empty2_ff <= empty1_ff;
      end
   end

   always_comb begin
      op_a[P_AX_LO] = coef_a_ff;  op_b[P_AX_LO] = req_box.x_lo;
      op_a[P_AX_HI] = coef_a_ff;  op_b[P_AX_HI] = req_box.x_hi;
      op_a[P_CY_LO] = coef_c_ff;  op_b[P_CY_LO] = req_box.y_lo;
      op_a[P_CY_HI] = coef_c_ff;  op_b[P_CY_HI] = req_box.y_hi;
      op_a[P_BX_LO] = coef_b_ff;  op_b[P_BX_LO] = req_box.x_lo;
      op_a[P_BX_HI] = coef_b_ff;  op_b[P_BX_HI] = req_box.x_hi;
      op_a[P_DY_LO] = coef_d_ff;  op_b[P_DY_LO] = req_box.y_lo;
      op_a[P_DY_HI] = coef_d_ff;  op_b[P_DY_HI] = req_box.y_hi;
   end

   for (genvar g = 0; g < NUM_PROD; g++) begin : g_mul
      abbx_fxmul u_mul (
         .clock   (clock),
         .en      (stage_en.st1),
         .op_a    (op_a[g]),
         .op_b    (op_b[g]),
         .prod_ff (prod[g])
      );
   end

   abbx_corner u_corner (
      .clock   (clock),
      .en      (stage_en.st2),
      .prod    (prod),
      .shift_x (shift_x_ff),
      .shift_y (shift_y_ff),
      .cx_ff   (cx),
      .cy_ff   (cy)
   );

   abbx_bound u_bound (
      .clock        (clock),
      .stage_en     (stage_en),
      .cx           (cx),
      .cy           (cy),
      .box          (box2_ff),
      .empty        (empty2_ff),
      .res_ff       (res_box),
      .res_empty_ff (res_empty)
   );

   assign rsp_tvalid = v4_ff;
   assign rsp_tdata  = {res_box.y_hi, res_box.x_hi, res_box.y_lo, res_box.x_lo};
   assign rsp_tuser  = res_empty;

endmodule

/* src/abbx_fxmul.sv */
// ----------------------------------------------------------------------------
// abbx_fxmul
// Registered signed 32x32 multiplier keeping the product bits that survive
// the 16.16 rounding shift.
// ----------------------------------------------------------------------------
module abbx_fxmul (
   input  logic              clock,
   input  logic              en,
   input  abbx_pkg::word_type op_a,
   input  abbx_pkg::word_type op_b,
   output abbx_pkg::prod_type prod_ff
);
   import abbx_pkg::*;

   logic signed [2*WORD_W-1:0] full_prod;
   prod_type                   prod_in;

   assign full_prod = (2*WORD_W)'(op_a) * (2*WORD_W)'(op_b);
   assign prod_in   = full_prod[PROD_W-1:0];

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end

endmodule

/* src/abbx_corner.sv */
// ----------------------------------------------------------------------------
// abbx_corner
// Rounds the registered products and sums them with the translation to form
// the four transformed corners.
// ----------------------------------------------------------------------------
module abbx_corner (
   input  logic               clock,
   input  logic               en,
   input  abbx_pkg::prod_type prod [abbx_pkg::NUM_PROD],
   input  abbx_pkg::word_type shift_x,
   input  abbx_pkg::word_type shift_y,
   output abbx_pkg::word_type cx_ff [abbx_pkg::NUM_CORN],
   output abbx_pkg::word_type cy_ff [abbx_pkg::NUM_CORN]
);
   import abbx_pkg::*;

   word_type ax_lo, ax_hi, cy_lo, cy_hi, bx_lo, bx_hi, dy_lo, dy_hi;
   word_type cx_in [NUM_CORN];
   word_type cy_in [NUM_CORN];

   assign ax_lo = fx_round(prod[P_AX_LO]);
   assign ax_hi = fx_round(prod[P_AX_HI]);
   assign cy_lo = fx_round(prod[P_CY_LO]);
   assign cy_hi = fx_round(prod[P_CY_HI]);
   assign bx_lo = fx_round(prod[P_BX_LO]);
   assign bx_hi = fx_round(prod[P_BX_HI]);
   assign dy_lo = fx_round(prod[P_DY_LO]);
   assign dy_hi = fx_round(prod[P_DY_HI]);

   // Corners in order (lo,lo), (hi,lo), (hi,hi), (lo,hi); sums wrap at 32 bits.
   always_comb begin
      cx_in[0] = ax_lo + cy_lo + shift_x;
      cx_in[1] = ax_hi + cy_lo + shift_x;
      cx_in[2] = ax_hi + cy_hi + shift_x;
      cx_in[3] = ax_lo + cy_hi + shift_x;
      cy_in[0] = bx_lo + dy_lo + shift_y;
      cy_in[1] = bx_hi + dy_lo + shift_y;
      cy_in[2] = bx_hi + dy_hi + shift_y;
      cy_in[3] = bx_lo + dy_hi + shift_y;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cx_ff <= cx_in;
         cy_ff <= cy_in;
      end
   end

endmodule

/* src/abbx_bound.sv */
// ----------------------------------------------------------------------------
// abbx_bound
// Two-level registered min/max tree over the corners, with the null
// rectangle bypass on the final level.
// ----------------------------------------------------------------------------
module abbx_bound (
   input  logic                   clock,
   input  abbx_pkg::stage_en_type stage_en,
   input  abbx_pkg::word_type     cx [abbx_pkg::NUM_CORN],
   input  abbx_pkg::word_type     cy [abbx_pkg::NUM_CORN],
   input  abbx_pkg::box_type      box,
   input  logic                   empty,
   output abbx_pkg::box_type      res_ff,
   output logic                   res_empty_ff
);
   import abbx_pkg::*;

   word_type xmin_ff [2];
   word_type xmax_ff [2];
   word_type ymin_ff [2];
   word_type ymax_ff [2];
   box_type  box_ff;
   logic     empty_ff;
   box_type  res_in;

   always_ff @(posedge clock) begin
      if (stage_en.st3) begin
         xmin_ff[0] <= smin(cx[0], cx[1]);
         xmin_ff[1] <= smin(cx[2], cx[3]);
         xmax_ff[0] <= smax(cx[0], cx[1]);
         xmax_ff[1] <= smax(cx[2], cx[3]);
         ymin_ff[0] <= smin(cy[0], cy[1]);
         ymin_ff[1] <= smin(cy[2], cy[3]);
         ymax_ff[0] <= smax(cy[0], cy[1]);
         ymax_ff[1] <= smax(cy[2], cy[3]);
         box_ff     <= box;
         empty_ff   <= empty;
      end
   end

   always_comb begin
      if (empty_ff) begin
         res_in = box_ff;
      end else begin
         res_in.x_lo = smin(xmin_ff[0], xmin_ff[1]);
         res_in.y_lo = smin(ymin_ff[0], ymin_ff[1]);
         res_in.x_hi = smax(xmax_ff[0], xmax_ff[1]);
         res_in.y_hi = smax(ymax_ff[0], ymax_ff[1]);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en.st4) begin
         res_ff       <= res_in;
         res_empty_ff <= empty_ff;
      end
   end

endmodule

/* src/abbx_checker.sv */
// ----------------------------------------------------------------------------
// abbx_checker
// Port-level checks for the affine bounding box transform, bound to the top.
// ----------------------------------------------------------------------------
module abbx_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic [abbx_pkg::BOX_W-1:0]     req_tdata,
   input logic                           req_tuser,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [abbx_pkg::BOX_W-1:0]     rsp_tdata,
   input logic                           rsp_tuser
);

   // The pipeline comes out of reset empty.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp beat presented right after reset");

   // A held rsp beat keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp beat changed while stalled");

   // With the sink always ready, an accepted beat emerges on rsp once it has crossed every pipeline stage.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && rsp_tready) ##1 rsp_tready ##1 rsp_tready
         ##1 rsp_tready |=> rsp_tvalid)
      else $error("rsp beat missing four cycles after accept");

   // A null rectangle comes back unchanged and flagged.
   a_null_pass: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser && rsp_tready) ##1 rsp_tready
         ##1 rsp_tready ##1 rsp_tready
         |=> rsp_tuser && (rsp_tdata == $past(req_tdata, 4)))
      else $error("null rectangle not passed through");

endmodule

bind affine_bbox_transform_q16_unit abbx_checker u_abbx_checker (.*);

/* dv/bbox_transform_checker.sv */
// ----------------------------------------------------------------------------
// bbox_transform_checker
// Watches the register port and both stream channels of the affine bounding
// box unit. It predicts the box for every accepted req beat and compares it,
// field by field, with the rsp beats in order.
// ----------------------------------------------------------------------------
module bbox_transform_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [abbx_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [abbx_pkg::WORD_W-1:0]    csr_wdata,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [abbx_pkg::BOX_W-1:0]     req_tdata,
   input  logic                           req_tuser,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [abbx_pkg::BOX_W-1:0]     rsp_tdata,
   input  logic                           rsp_tuser,
   output int                             fail_count,
   output int                             boxes_pending
);

   timeunit 1ns;
   timeprecision 1ps;

   import abbx_pkg::*;

   typedef struct {
      word_type x_lo;
      word_type y_lo;
      word_type x_hi;
      word_type y_hi;
      logic     empty;
   } bbox_type;

   word_type coef_a, coef_b, coef_c, coef_d, shift_x, shift_y;
   bbox_type expected_boxes[$];
   int       reported = 0;

   // Rounded 16.16 product; the 64-bit sum is exact, so bits 47:16 are the
   // arithmetic shift by 16 truncated to one word.
   function automatic word_type q16_mul(input word_type coef, input word_type v);
      longint p;
      p = longint'(coef) * longint'(v) + 64'sd32768;
      return word_type'(p[47:16]);
   endfunction

   function automatic bbox_type unpack_box(input logic [BOX_W-1:0] data, input logic flag);
      bbox_type b;
      b.x_lo  = data[31:0];
      b.y_lo  = data[63:32];
      b.x_hi  = data[95:64];
      b.y_hi  = data[127:96];
      b.empty = flag;
      return b;
   endfunction

   function automatic bbox_type transform_bbox(input bbox_type box);
      bbox_type r;
      word_type px, py, cx, cy;
      r = box;
      if (box.empty) begin
         return r;
      end
      // Corners in order: (lo,lo), (hi,lo), (hi,hi), (lo,hi).
      for (int i = 0; i < 4; i++) begin
         px = (i == 0 || i == 3) ? box.x_lo : box.x_hi;
         py = (i < 2) ? box.y_lo : box.y_hi;
         cx = q16_mul(coef_a, px) + q16_mul(coef_c, py) + shift_x;
         cy = q16_mul(coef_b, px) + q16_mul(coef_d, py) + shift_y;
         if (i == 0 || cx < r.x_lo) r.x_lo = cx;
         if (i == 0 || cx > r.x_hi) r.x_hi = cx;
         if (i == 0 || cy < r.y_lo) r.y_lo = cy;
         if (i == 0 || cy > r.y_hi) r.y_hi = cy;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      bbox_type got, want;
      if (reset) begin
         coef_a  = ONE_Q16;
         coef_b  = '0;
         coef_c  = '0;
         coef_d  = ONE_Q16;
         shift_x = '0;
         shift_y = '0;
         expected_boxes.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = unpack_box(rsp_tdata, rsp_tuser);
            if (expected_boxes.size() == 0) begin
               fail_count++;
               if (reported < 10) begin
                  reported++;
                  $display("%t rsp beat with nothing pending: box %h %h %h %h empty %b",
                           $realtime, got.x_lo, got.y_lo, got.x_hi, got.y_hi, got.empty);
               end
            end else begin
               want = expected_boxes.pop_front();
               if (got.x_lo !== want.x_lo || got.y_lo !== want.y_lo ||
                   got.x_hi !== want.x_hi || got.y_hi !== want.y_hi ||
                   got.empty !== want.empty) begin
                  fail_count++;
                  if (reported < 10) begin
                     reported++;
                     $display("%t mismatch exp/act xl %h/%h yl %h/%h xh %h/%h yh %h/%h e %b/%b",
                              $realtime, want.x_lo, got.x_lo, want.y_lo, got.y_lo,
                              want.x_hi, got.x_hi, want.y_hi, got.y_hi,
                              want.empty, got.empty);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            expected_boxes.push_back(transform_bbox(unpack_box(req_tdata, req_tuser)));
         end
         // Writes land only while the unit is idle, so ordering after the
         // prediction above is safe.
         if (csr_wr_en) begin
            case (csr_index)
               CSR_COEF_A:  coef_a  = csr_wdata;
               CSR_COEF_B:  coef_b  = csr_wdata;
               CSR_COEF_C:  coef_c  = csr_wdata;
               CSR_COEF_D:  coef_d  = csr_wdata;
               CSR_SHIFT_X: shift_x = csr_wdata;
               CSR_SHIFT_Y: shift_y = csr_wdata;
               default: ;
            endcase
         end
      end
      boxes_pending = expected_boxes.size();
   end

endmodule

/* dv/tb_affine_bbox_transform_q16_unit.sv */
// ----------------------------------------------------------------------------
// tb_affine_bbox_transform_q16_unit
// Drives boxes through the affine bounding box unit under a series of
// matrices, from identity through extreme and random coefficients, with
// random stalls on both channels. A separate checker predicts every result.
// ----------------------------------------------------------------------------
module tb_affine_bbox_transform_q16_unit;

   timeunit 1ns;
   timeprecision 1ps;

   import abbx_pkg::*;

   localparam int PIPE_LATENCY = 4;
   localparam int IDLE_PCT     = 16;

   // Indexes past the last register; writes there must be dropped.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_6 = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_7 = 3'd7;

   localparam word_type W_MIN = 32'sh8000_0000;
   localparam word_type W_MAX = 32'sh7fff_ffff;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 csr_wr_en  = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [WORD_W-1:0]    csr_wdata  = '0;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [BOX_W-1:0]     req_tdata  = '0;
   logic                 req_tuser  = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [BOX_W-1:0]     rsp_tdata;
   logic                 rsp_tuser;

   int fail_count;
   int boxes_pending;
   bit steady = 1'b0;

   always #5 clock = ~clock;

   affine_bbox_transform_q16_unit dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   bbox_transform_checker u_bbox_check (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .fail_count    (fail_count),
      .boxes_pending (boxes_pending)
   );

   always @(negedge clock) begin
      rsp_tready = steady || ($urandom_range(99) >= IDLE_PCT);
   end

   function automatic word_type pick_coord();
      case ($urandom_range(11))
         0:       return W_MIN;
         1:       return W_MAX;
         2:       return -32'sd1;
         3:       return '0;
         4, 5, 6: return word_type'($urandom) >>> 8;
         default: return word_type'($urandom);
      endcase
   endfunction

   function automatic word_type pick_coef();
      case ($urandom_range(9))
         0:       return ONE_Q16;
         1:       return -ONE_Q16;
         2:       return '0;
         3:       return W_MIN;
         4:       return W_MAX;
         5, 6, 7: return word_type'($urandom) >>> 13;
         default: return word_type'($urandom);
      endcase
   endfunction

   task automatic send_box(input word_type xl, input word_type yl, input word_type xh,
                           input word_type yh, input logic empty);
      @(negedge clock);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tdata  = {yh, xh, yl, xl};
      req_tuser  = empty;
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_random_box();
      word_type a, b, c, d, t;
      int       kind;
      a = pick_coord();
      b = pick_coord();
      c = pick_coord();
      d = pick_coord();
      kind = $urandom_range(15);
      if (kind == 0) begin
         send_box(a, b, c, d, 1'b1);
      end else if (kind < 3) begin
         send_box(a, b, a, b, 1'b0);
      end else if (kind < 5) begin
         // Bounds in whatever order they came, often inverted.
         send_box(a, b, c, d, 1'b0);
      end else begin
         if (a > c) begin t = a; a = c; c = t; end
         if (b > d) begin t = b; b = d; d = t; end
         send_box(a, b, c, d, 1'b0);
      end
   endtask

   // Lets the pipeline drain so that registers can be changed safely.
   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (boxes_pending != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 2) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input word_type value);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic load_matrix(input word_type a, input word_type b, input word_type c,
                              input word_type d, input word_type tx, input word_type ty);
      write_reg(CSR_COEF_A, a);
      write_reg(CSR_COEF_B, b);
      write_reg(CSR_COEF_C, c);
      write_reg(CSR_COEF_D, d);
      write_reg(CSR_SHIFT_X, tx);
      write_reg(CSR_SHIFT_Y, ty);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Identity matrix straight out of reset.
      send_box(W_MIN, W_MIN, W_MAX, W_MAX, 1'b0);
      send_box(W_MAX, W_MAX, W_MIN, W_MIN, 1'b0);
      send_box('0, '0, '0, '0, 1'b0);
      send_box(-32'sd1, -32'sd1, -32'sd1, -32'sd1, 1'b0);
      send_box(32'sd1, 32'sd2, 32'sd3, 32'sd4, 1'b1);
      send_box(W_MIN, W_MAX, -32'sd1, '0, 1'b1);
      send_box(32'sh0001_8000, -32'sh0000_8000, 32'sh0002_0000, 32'sh0000_8000, 1'b0);

      // Largest coefficients and translations: heavy wrap in every sum.
      drain();
      load_matrix(W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX);
      send_box(W_MIN, W_MIN, W_MAX, W_MAX, 1'b0);
      send_box(W_MAX, W_MIN, W_MAX, W_MIN, 1'b0);
      send_box(-32'sd1, 32'sd1, 32'sd1, -32'sd1, 1'b0);
      send_box(W_MAX, W_MAX, W_MAX, W_MAX, 1'b1);

      drain();
      load_matrix(W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN);
      send_box(W_MIN, W_MIN, W_MAX, W_MAX, 1'b0);
      send_box(W_MIN, W_MIN, W_MIN, W_MIN, 1'b0);
      send_box(32'sh0000_8000, -32'sh0000_8000, -32'sd1, 32'sd1, 1'b0);

      // Roughly a 45 degree rotation with an offset, then junk at the
      // unused indexes, which must leave it untouched.
      drain();
      load_matrix(32'sd46341, 32'sd46341, -32'sd46341, 32'sd46341,
                  32'sh0010_0000, -32'sh0020_0000);
      write_reg(CSR_SPARE_6, 32'sh1234_5678);
      write_reg(CSR_SPARE_7, W_MIN);
      send_box(-32'sh0004_0000, -32'sh0002_0000, 32'sh0004_0000, 32'sh0002_0000, 1'b0);
      send_box(32'sh0003_0000, 32'sh0001_0000, -32'sh0003_0000, -32'sh0001_0000, 1'b0);
      send_box(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 1'b0);
      send_box(W_MIN, W_MAX, W_MAX, W_MIN, 1'b0);

      for (int phase = 0; phase < 8; phase++) begin
         if (phase > 0) begin
            drain();
            load_matrix(pick_coef(), pick_coef(), pick_coef(), pick_coef(),
                        pick_coord(), pick_coord());
         end
         // One phase runs with both sides at full rate.
         steady = (phase == 3);
         repeat (210) send_random_box();
      end

      steady = 1'b0;
      drain();
      repeat (PIPE_LATENCY + 4) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_affine_bbox_transform_q16_unit passed");
      end else begin
         $display("tb_affine_bbox_transform_q16_unit failed");
      end
      $finish;
   end

   initial begin
      #3ms;
      $display("tb_affine_bbox_transform_q16_unit failed");
      $finish;
   end

endmodule

/* files.f */
src/abbx_pkg.sv
src/abbx_fxmul.sv
src/abbx_corner.sv
src/abbx_bound.sv
src/affine_bbox_transform_q16_unit.sv
src/abbx_checker.sv
dv/bbox_transform_checker.sv
dv/tb_affine_bbox_transform_q16_unit.sv
